@@ rtl/sbt_pkg.sv @@
// Shared types and constants for the source byte tokenizer.
// No dependencies; used by sbt_step, sbt_out_buf and source_byte_tokenizer_top.
package sbt_pkg;

    // Width of the internal line counter; result line fields have the same width
    localparam int LINE_BITS       = 24;
    localparam int TOKEN_LINE_BITS = 24;
    localparam int NAME_LEN_BITS   = 9;

    localparam logic [NAME_LEN_BITS-1:0] MAX_NAME_LEN_RESET = 9'd255;

    // Register map (byte addresses)
    localparam logic [2:0] ADDR_MAX_NAME_LEN = 3'd0;

    typedef logic [LINE_BITS-1:0]       line_t;
    typedef logic [TOKEN_LINE_BITS-1:0] tok_line_t;

    typedef enum logic [3:0] {
        KIND_BAD_CHAR   = 4'd0,
        KIND_EOF        = 4'd1,
        KIND_SEMICOLON  = 4'd2,
        KIND_COMMA      = 4'd3,
        KIND_OPEN       = 4'd4,
        KIND_CLOSE      = 4'd5,
        KIND_NAME_CHAR  = 4'd6,
        KIND_NAME_END   = 4'd7,
        KIND_STR_CHAR   = 4'd8,
        KIND_STR_END    = 4'd9,
        KIND_NAME_LONG  = 4'd10
    } token_kind_t;

    typedef struct packed {
        token_kind_t kind;
        logic [7:0]  ch;
        tok_line_t   line;
    } sbt_token_t;

    // Up to two tokens produced by one input word
    typedef struct packed {
        logic [1:0] count;
        sbt_token_t first;
        sbt_token_t second;
    } sbt_step_out_t;

endpackage

@@ rtl/source_byte_tokenizer_top.sv @@
// Source byte tokenizer top level: stream ports, config register, lexer and result buffer.
// Depends on sbt_pkg, sbt_step and sbt_out_buf.
//
//  channel   | dir | handshake          | content
//  ----------+-----+--------------------+------------------------------------------
//  s_ (byte) | in  | s_tvalid/s_tready  | tdata: source byte; tuser: end mark
//  m_ (token)| out | m_tvalid/m_tready  | tuser: kind; tdata: char, line; tlast
//  apb       | in  | psel/penable       | max_name_length at address 0
//
// Each accepted word is lexed in the cycle it is accepted; its tokens appear on m_
// from the next cycle. A word giving two tokens holds off the next word until the second
// of them leaves through the single output port of the two-slot result register.
// Reset (aresetn low at a clock edge) returns the lexer to idle with line zero and the
// name limit to 255. A stalled m_ side holds the tokens and s_tready drops once a
// second word would not fit.
module source_byte_tokenizer_top (
    input  logic        aclk,
    input  logic        aresetn,
    // byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] source_byte
    input  logic [0:0]  s_tuser,   // [0] end_of_input
    // token stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] char_value, [31:8] token_line
    output logic [3:0]  m_tuser,   // [3:0] token_kind
    output logic        m_tlast,   // last_of_run
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [8:0]             max_len_reg;
    logic                   accept;
    logic                   can_load;
    sbt_pkg::sbt_step_out_t step_out;
    sbt_pkg::sbt_token_t    head_tok;
    logic                   head_last;
    logic                   reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2] == sbt_pkg::ADDR_MAX_NAME_LEN[2];

    // Config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= sbt_pkg::MAX_NAME_LEN_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            max_len_reg <= pwdata[8:0];
        end
    end

    assign prdata = reg_sel ? {23'd0, max_len_reg} : 32'd0;

    assign s_tready = can_load;
    assign accept   = s_tvalid && s_tready;

    sbt_step u_step (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .source_byte     (s_tdata),
        .end_of_input    (s_tuser[0]),
        .max_name_length (max_len_reg),
        .step_out        (step_out)
    );

    sbt_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept),
        .step_out  (step_out),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .head_tok  (head_tok),
        .head_last (head_last),
        .can_load  (can_load)
    );

    assign m_tuser = head_tok.kind;
    assign m_tdata = {head_tok.line, head_tok.ch};
    assign m_tlast = head_last;

endmodule

@@ rtl/sbt_step.sv @@
// Lexer state and the combinational step that turns one input word into tokens.
// Depends on sbt_pkg.
module sbt_step (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [7:0]            source_byte,
    input  logic                  end_of_input,
    input  logic [8:0]            max_name_length,
    output sbt_pkg::sbt_step_out_t step_out
);

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_NAME = 3'd1,
        MODE_STR  = 3'd2,
        MODE_ESC  = 3'd3,
        MODE_HALT = 3'd4
    } mode_t;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == CH_UNDER;
    endfunction

    function automatic logic is_namechar(input logic [7:0] c);
        return is_alpha(c) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h74:   r = 8'h09;   // t
            8'h6E:   r = 8'h0A;   // n
            8'h76:   r = 8'h0B;   // v
            8'h66:   r = 8'h0C;   // f
            8'h72:   r = 8'h0D;   // r
            default: r = c;
        endcase
        return r;
    endfunction

    // Saturating newline count
    function automatic sbt_pkg::line_t line_inc(input sbt_pkg::line_t ln, input logic [7:0] c);
        sbt_pkg::line_t r;
        r = ln;
        if (c == CH_LF && !(&ln)) begin
            r = ln + sbt_pkg::line_t'(1);
        end
        return r;
    endfunction

    mode_t                     mode_reg, mode_next;
    sbt_pkg::line_t            line_reg, line_next;
    sbt_pkg::line_t            start_reg, start_next;
    logic [8:0]                nlen_reg, nlen_next;

    sbt_pkg::tok_line_t        cur_line, name_line;

    // Between-tokens handling of the byte
    logic                      idle_emit;
    sbt_pkg::sbt_token_t       idle_tok;
    mode_t                     idle_mode;
    sbt_pkg::line_t            idle_line, idle_start;
    logic [8:0]                idle_nlen;

    assign cur_line  = sbt_pkg::tok_line_t'(line_reg);
    assign name_line = sbt_pkg::tok_line_t'(start_reg);

    always_comb begin
        idle_emit  = 1'b0;
        idle_tok   = '{kind: sbt_pkg::KIND_BAD_CHAR, ch: source_byte, line: cur_line};
        idle_mode  = MODE_IDLE;
        idle_line  = line_reg;
        idle_start = start_reg;
        idle_nlen  = nlen_reg;
        if (source_byte == CH_SPACE || (source_byte >= CH_TAB && source_byte <= CH_CR)) begin
            idle_line = line_inc(line_reg, source_byte);
        end else begin
            case (source_byte)
                CH_SEMI: begin
                    idle_emit = 1'b1;
                    idle_tok  = '{kind: sbt_pkg::KIND_SEMICOLON, ch: 8'd0, line: cur_line};
                end
                CH_COMMA: begin
                    idle_emit = 1'b1;
                    idle_tok  = '{kind: sbt_pkg::KIND_COMMA, ch: 8'd0, line: cur_line};
                end
                CH_OPEN: begin
                    idle_emit = 1'b1;
                    idle_tok  = '{kind: sbt_pkg::KIND_OPEN, ch: 8'd0, line: cur_line};
                end
                CH_CLOSE: begin
                    idle_emit = 1'b1;
                    idle_tok  = '{kind: sbt_pkg::KIND_CLOSE, ch: 8'd0, line: cur_line};
                end
                default: begin
                    if (is_alpha(source_byte)) begin
                        // first name char; a zero limit rejects it at once
                        idle_emit  = 1'b1;
                        idle_start = line_reg;
                        if (max_name_length == 9'd0) begin
                            idle_mode = MODE_HALT;
                            idle_nlen = 9'd0;
                            idle_tok  = '{kind: sbt_pkg::KIND_NAME_LONG, ch: source_byte,
                                          line: cur_line};
                        end else begin
                            idle_mode = MODE_NAME;
                            idle_nlen = 9'd1;
                            idle_tok  = '{kind: sbt_pkg::KIND_NAME_CHAR, ch: source_byte,
                                          line: cur_line};
                        end
                    end else if (source_byte == CH_QUOTE) begin
                        idle_mode  = MODE_STR;
                        idle_start = line_reg;
                    end else begin
                        idle_emit = 1'b1;
                    end
                end
            endcase
        end
    end

    // Main step, per mode
    always_comb begin
        mode_next  = mode_reg;
        line_next  = line_reg;
        start_next = start_reg;
        nlen_next  = nlen_reg;
        step_out   = '0;
        if (mode_reg == MODE_HALT) begin
            step_out.count = 2'd0;
        end else if (end_of_input) begin
            mode_next = MODE_IDLE;
            if (mode_reg == MODE_NAME || mode_reg == MODE_STR || mode_reg == MODE_ESC) begin
                step_out.count       = 2'd2;
                step_out.first.kind  = (mode_reg == MODE_NAME) ? sbt_pkg::KIND_NAME_END
                                                               : sbt_pkg::KIND_STR_END;
                step_out.first.line  = name_line;
                step_out.second.kind = sbt_pkg::KIND_EOF;
                step_out.second.line = cur_line;
            end else begin
                step_out.count      = 2'd1;
                step_out.first.kind = sbt_pkg::KIND_EOF;
                step_out.first.line = cur_line;
            end
        end else begin
            unique case (mode_reg)
                MODE_NAME: begin
                    if (is_namechar(source_byte)) begin
                        step_out.count      = 2'd1;
                        step_out.first.ch   = source_byte;
                        step_out.first.line = name_line;
                        if (nlen_reg >= max_name_length) begin
                            step_out.first.kind = sbt_pkg::KIND_NAME_LONG;
                            mode_next           = MODE_HALT;
                        end else begin
                            step_out.first.kind = sbt_pkg::KIND_NAME_CHAR;
                            nlen_next           = nlen_reg + 9'd1;
                        end
                    end else begin
                        // name ends, then the byte is lexed from idle
                        step_out.count      = idle_emit ? 2'd2 : 2'd1;
                        step_out.first.kind = sbt_pkg::KIND_NAME_END;
                        step_out.first.line = name_line;
                        step_out.second     = idle_tok;
                        mode_next           = idle_mode;
                        line_next           = idle_line;
                        start_next          = idle_start;
                        nlen_next           = idle_nlen;
                    end
                end
                MODE_STR: begin
                    line_next = line_inc(line_reg, source_byte);
                    if (source_byte == CH_QUOTE) begin
                        step_out.count      = 2'd1;
                        step_out.first.kind = sbt_pkg::KIND_STR_END;
                        step_out.first.line = name_line;
                        mode_next           = MODE_IDLE;
                    end else if (source_byte == CH_BSLASH) begin
                        mode_next = MODE_ESC;
                    end else begin
                        step_out.count      = 2'd1;
                        step_out.first.kind = sbt_pkg::KIND_STR_CHAR;
                        step_out.first.ch   = source_byte;
                        step_out.first.line = name_line;
                    end
                end
                MODE_ESC: begin
                    line_next           = line_inc(line_reg, source_byte);
                    step_out.count      = 2'd1;
                    step_out.first.kind = sbt_pkg::KIND_STR_CHAR;
                    step_out.first.ch   = unescape(source_byte);
                    step_out.first.line = name_line;
                    mode_next           = MODE_STR;
                end
                default: begin
                    step_out.count = idle_emit ? 2'd1 : 2'd0;
                    step_out.first = idle_tok;
                    mode_next      = idle_mode;
                    line_next      = idle_line;
                    start_next     = idle_start;
                    nlen_next      = idle_nlen;
                end
            endcase
        end
    end

    // Lexer state advances only on an accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            line_reg  <= '0;
            start_reg <= '0;
            nlen_reg  <= '0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            start_reg <= start_next;
            nlen_reg  <= nlen_next;
        end
    end

    // Halt is sticky until reset
    assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_HALT |=> mode_reg == MODE_HALT)
        else $error("sbt_step: left halt without reset");

    // A halted lexer produces nothing
    assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_HALT |-> step_out.count == 2'd0)
        else $error("sbt_step: tokens while halted");

    // Name length stays within nine bits (at most 511) while collecting a name
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && mode_reg == MODE_NAME && mode_next == MODE_NAME |-> nlen_next <= 9'd511)
        else $error("sbt_step: name length overflow");

    // End mark always yields at least the eof token unless halted
    assert property (@(posedge aclk) disable iff (!aresetn)
        end_of_input && mode_reg != MODE_HALT |-> step_out.count != 2'd0)
        else $error("sbt_step: end mark without eof");

endmodule

@@ rtl/sbt_out_buf.sv @@
// Two-slot result register: holds the tokens of one input word and drains them.
// Depends on sbt_pkg.
module sbt_out_buf (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  sbt_pkg::sbt_step_out_t step_out,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output sbt_pkg::sbt_token_t    head_tok,
    output logic                   head_last,
    output logic                   can_load
);

    logic [1:0]          cnt_reg, cnt_next;
    sbt_pkg::sbt_token_t slot0_reg, slot1_reg;
    logic                last0_reg;
    logic                pop;

    assign m_tvalid  = cnt_reg != 2'd0;
    assign head_tok  = slot0_reg;
    assign head_last = last0_reg;
    assign pop       = m_tvalid && m_tready;
    // take a new word when the last held word leaves this cycle or nothing is held
    assign can_load  = cnt_reg == 2'd0 || (cnt_reg == 2'd1 && m_tready);

    always_comb begin
        cnt_next = cnt_reg;
        if (load) begin
            cnt_next = step_out.count;
        end else if (pop) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Payload slots, no reset
    always_ff @(posedge aclk) begin
        if (load) begin
            slot0_reg <= step_out.first;
            last0_reg <= step_out.count == 2'd1;
            slot1_reg <= step_out.second;
        end else if (pop && cnt_reg == 2'd2) begin
            slot0_reg <= slot1_reg;
            last0_reg <= 1'b1;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("sbt_out_buf: slot count out of range");

    // Head is last exactly when it is the only word held
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (head_last == (cnt_reg == 2'd1)))
        else $error("sbt_out_buf: last flag mismatch");

    // Never overwrite undelivered words
    assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop))
        else $error("sbt_out_buf: load over pending words");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for source_byte_tokenizer_top: a table of directed words, then
// random token-shaped byte streams under several name limits, checked against a local lexer.
// Depends on sbt_pkg and the RTL of source_byte_tokenizer_top.
module testbench;
    import sbt_pkg::*;

    // Byte values the lexer treats specially
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    localparam int          SETTLE_CYCLES = 4;
    localparam int          STALL_CYCLES  = 300;
    localparam int          LONG_NAME_LEN = 300;
    localparam int unsigned PRINT_CAP     = 30;

    typedef enum logic [2:0] {
        LX_IDLE = 3'd0,
        LX_NAME = 3'd1,
        LX_STR  = 3'd2,
        LX_ESC  = 3'd3,
        LX_HALT = 3'd4
    } lex_mode_e;

    typedef struct packed {
        lex_mode_e  mode;
        line_t      line;
        line_t      start;
        logic [8:0] len;
        logic [8:0] limit;
    } lex_state_t;

    // One source word; the typed fields hold the count and the last token of the
    // word where a directed row spells them out
    typedef struct packed {
        logic [7:0]  b;
        logic        eoi;
        logic        typed;
        logic [1:0]  n;
        token_kind_t kind;
        logic [7:0]  ch;
        tok_line_t   line;
    } src_word_t;

    typedef struct packed {
        sbt_token_t tok;
        logic       last;
    } expected_tok_t;

    localparam src_word_t DIRECTED [27] = '{
        '{8'hFF,     1'b1, 1'b1, 2'd1, KIND_EOF,       8'h00,     24'd0}, // end mark, byte ignored
        '{CH_SPACE,  1'b0, 1'b1, 2'd0, KIND_BAD_CHAR,  8'h00,     24'd0},
        '{CH_TAB,    1'b0, 1'b1, 2'd0, KIND_BAD_CHAR,  8'h00,     24'd0},
        '{CH_LF,     1'b0, 1'b1, 2'd0, KIND_BAD_CHAR,  8'h00,     24'd0}, // now line 1
        '{CH_SEMI,   1'b0, 1'b1, 2'd1, KIND_SEMICOLON, 8'h00,     24'd1},
        '{CH_COMMA,  1'b0, 1'b1, 2'd1, KIND_COMMA,     8'h00,     24'd1},
        '{CH_OPEN,   1'b0, 1'b1, 2'd1, KIND_OPEN,      8'h00,     24'd1},
        '{CH_CLOSE,  1'b0, 1'b1, 2'd1, KIND_CLOSE,     8'h00,     24'd1},
        '{8'h00,     1'b0, 1'b1, 2'd1, KIND_BAD_CHAR,  8'h00,     24'd1},
        '{8'hFF,     1'b0, 1'b1, 2'd1, KIND_BAD_CHAR,  8'hFF,     24'd1},
        '{CH_UNDER,  1'b0, 1'b1, 2'd1, KIND_NAME_CHAR, CH_UNDER,  24'd1},
        '{8'h5A,     1'b0, 1'b0, 2'd0, KIND_BAD_CHAR,  8'h00,     24'd0}, // Z
        '{8'h39,     1'b0, 1'b0, 2'd0, KIND_BAD_CHAR,  8'h00,     24'd0}, // 9
        '{CH_SEMI,   1'b0, 1'b1, 2'd2, KIND_SEMICOLON, 8'h00,     24'd1}, // name end, then ;
        '{8'h61,     1'b0, 1'b1, 2'd1, KIND_NAME_CHAR, 8'h61,     24'd1},
        '{8'h00,     1'b1, 1'b1, 2'd2, KIND_EOF,       8'h00,     24'd1}, // end inside a name
        '{CH_QUOTE,  1'b0, 1'b1, 2'd0, KIND_BAD_CHAR,  8'h00,     24'd0},
        '{CH_BSLASH, 1'b0, 1'b1, 2'd0, KIND_BAD_CHAR,  8'h00,     24'd0},
        '{8'h6E,     1'b0, 1'b1, 2'd1, KIND_STR_CHAR,  CH_LF,     24'd1}, // \n decoded
        '{CH_BSLASH, 1'b0, 1'b1, 2'd0, KIND_BAD_CHAR,  8'h00,     24'd0},
        '{CH_LF,     1'b0, 1'b1, 2'd1, KIND_STR_CHAR,  CH_LF,     24'd1}, // raw LF after escape
        '{CH_BSLASH, 1'b0, 1'b1, 2'd0, KIND_BAD_CHAR,  8'h00,     24'd0},
        '{8'h71,     1'b0, 1'b1, 2'd1, KIND_STR_CHAR,  8'h71,     24'd1}, // unknown escape
        '{CH_QUOTE,  1'b0, 1'b1, 2'd1, KIND_STR_END,   8'h00,     24'd1},
        '{CH_QUOTE,  1'b0, 1'b1, 2'd0, KIND_BAD_CHAR,  8'h00,     24'd0},
        '{CH_BSLASH, 1'b0, 1'b1, 2'd0, KIND_BAD_CHAR,  8'h00,     24'd0},
        '{8'h00,     1'b1, 1'b1, 2'd2, KIND_EOF,       8'h00,     24'd2}  // end in string
    };

    localparam logic [7:0] ESC_TARGETS [8] = '{
        8'h74, 8'h6E, 8'h76, 8'h66, 8'h72, CH_BSLASH, CH_QUOTE, 8'h27
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic [0:0]  s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    lex_state_t      pred_st;     // lexer copy advanced on accepted words
    lex_state_t      plan_st;     // lexer copy advanced while words are planned
    src_word_t       src_words[$];
    expected_tok_t   token_q[$];
    int unsigned     sent_idx     = 0;
    int unsigned     words_taken  = 0;
    int unsigned     tokens_seen  = 0;
    int unsigned     mismatches   = 0;
    int              sink_hold    = 0;
    bit              jitter_on    = 1'b1;
    bit              halt_allowed = 1'b0;

    source_byte_tokenizer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- lexer predictor
    function automatic bit is_lead(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || b == CH_UNDER;
    endfunction

    function automatic bit is_name_byte(input logic [7:0] b);
        return is_lead(b) || (b >= 8'h30 && b <= 8'h39);
    endfunction

    function automatic logic [7:0] decode_escape(input logic [7:0] b);
        case (b)
            8'h74:   return 8'h09;
            8'h6E:   return 8'h0A;
            8'h76:   return 8'h0B;
            8'h66:   return 8'h0C;
            8'h72:   return 8'h0D;
            default: return b;
        endcase
    endfunction

    function automatic void add_token(inout sbt_step_out_t r, input token_kind_t k,
                                      input logic [7:0] c, input line_t l);
        sbt_token_t t;
        t.kind = k;
        t.ch   = c;
        t.line = l[TOKEN_LINE_BITS-1:0];
        if (r.count == 2'd0) r.first = t;
        else r.second = t;
        r.count = r.count + 2'd1;
    endfunction

    // Raw LF bumps the line count, which sticks at all ones
    function automatic void count_lf(inout lex_state_t st, input logic [7:0] b);
        if (b == CH_LF && st.line != '1) st.line = st.line + 1'b1;
    endfunction

    function automatic void take_name_char(inout lex_state_t st, inout sbt_step_out_t r,
                                           input logic [7:0] b);
        if (st.len >= st.limit) begin
            add_token(r, KIND_NAME_LONG, b, st.start);
            st.mode = LX_HALT;
        end else begin
            st.len = st.len + 1'b1;
            add_token(r, KIND_NAME_CHAR, b, st.start);
        end
    endfunction

    function automatic void idle_byte(inout lex_state_t st, inout sbt_step_out_t r,
                                      input logic [7:0] b);
        if (b == CH_SPACE || (b >= 8'd9 && b <= 8'd13)) begin
            count_lf(st, b);
        end else begin
            case (b)
                CH_SEMI:  add_token(r, KIND_SEMICOLON, 8'h00, st.line);
                CH_COMMA: add_token(r, KIND_COMMA, 8'h00, st.line);
                CH_OPEN:  add_token(r, KIND_OPEN, 8'h00, st.line);
                CH_CLOSE: add_token(r, KIND_CLOSE, 8'h00, st.line);
                default: begin
                    if (is_lead(b)) begin
                        st.mode  = LX_NAME;
                        st.start = st.line;
                        st.len   = '0;
                        take_name_char(st, r, b);
                    end else if (b == CH_QUOTE) begin
                        st.mode  = LX_STR;
                        st.start = st.line;
                    end else begin
                        add_token(r, KIND_BAD_CHAR, b, st.line);
                    end
                end
            endcase
        end
    endfunction

    // Tokens caused by one source word
    function automatic sbt_step_out_t lex_step(inout lex_state_t st, input logic [7:0] b,
                                               input logic eoi);
        sbt_step_out_t r;
        r = '0;
        if (st.mode != LX_HALT) begin
            if (eoi) begin
                if (st.mode == LX_NAME)
                    add_token(r, KIND_NAME_END, 8'h00, st.start);
                else if (st.mode == LX_STR || st.mode == LX_ESC)
                    add_token(r, KIND_STR_END, 8'h00, st.start);
                st.mode = LX_IDLE;
                add_token(r, KIND_EOF, 8'h00, st.line);
            end else begin
                case (st.mode)
                    LX_NAME: begin
                        if (is_name_byte(b)) begin
                            take_name_char(st, r, b);
                        end else begin
                            add_token(r, KIND_NAME_END, 8'h00, st.start);
                            st.mode = LX_IDLE;
                            idle_byte(st, r, b);
                        end
                    end
                    LX_STR: begin
                        count_lf(st, b);
                        if (b == CH_QUOTE) begin
                            add_token(r, KIND_STR_END, 8'h00, st.start);
                            st.mode = LX_IDLE;
                        end else if (b == CH_BSLASH) begin
                            st.mode = LX_ESC;
                        end else begin
                            add_token(r, KIND_STR_CHAR, b, st.start);
                        end
                    end
                    LX_ESC: begin
                        count_lf(st, b);
                        add_token(r, KIND_STR_CHAR, decode_escape(b), st.start);
                        st.mode = LX_STR;
                    end
                    default: begin
                        st.mode = LX_IDLE;
                        idle_byte(st, r, b);
                    end
                endcase
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- checking
    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP) $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // Input words feed the predictor before output words pop it, in one process
    always @(posedge aclk) begin : token_check
        sbt_step_out_t step_r;
        src_word_t     row;
        sbt_token_t    row_last;
        expected_tok_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                step_r = lex_step(pred_st, s_tdata, s_tuser[0]);
                if (step_r.count >= 2'd1) token_q.push_back({step_r.first, step_r.count == 2'd1});
                if (step_r.count == 2'd2) token_q.push_back({step_r.second, 1'b1});
                if (words_taken < src_words.size()) begin
                    row = src_words[words_taken];
                    row_last = (step_r.count == 2'd2) ? step_r.second : step_r.first;
                    if (row.typed && (step_r.count != row.n || (row.n != 2'd0 &&
                        row_last != {row.kind, row.ch, row.line})))
                        report_mismatch($sformatf("word %0d: table says %0d tokens, last %0d/%h/%0d",
                            words_taken, row.n, row.kind, row.ch, row.line));
                end
                words_taken++;
            end
            if (m_tvalid && m_tready) begin
                tokens_seen++;
                if (token_q.size() == 0) begin
                    report_mismatch($sformatf("token kind %0d with nothing expected", m_tuser));
                end else begin
                    want = token_q.pop_front();
                    if (m_tuser != want.tok.kind)
                        report_mismatch($sformatf("token %0d kind %0d, want %0d",
                            tokens_seen, m_tuser, want.tok.kind));
                    if (m_tdata[7:0] != want.tok.ch)
                        report_mismatch($sformatf("token %0d char %h, want %h",
                            tokens_seen, m_tdata[7:0], want.tok.ch));
                    if (m_tdata[31:8] != want.tok.line)
                        report_mismatch($sformatf("token %0d line %0d, want %0d",
                            tokens_seen, m_tdata[31:8], want.tok.line));
                    if (m_tlast != want.last)
                        report_mismatch($sformatf("token %0d tlast %b, want %b",
                            tokens_seen, m_tlast, want.last));
                end
            end
        end
    end

    // ---------------------------------------------------------------- token sink
    initial begin
        forever begin
            @(negedge aclk);
            if (sink_hold > 0) begin
                m_tready <= 1'b0;
                sink_hold--;
            end else begin
                m_tready <= !(jitter_on && $urandom_range(99) < 27);
            end
        end
    end

    // ---------------------------------------------------------------- stimulus planning
    // Words go through the planning lexer; outside the final phase a byte that would
    // overflow the name limit is swapped for a space, which closes the name instead
    task automatic plan_word(input logic [7:0] b, input logic eoi);
        lex_state_t    trial;
        src_word_t     w;
        trial = plan_st;
        void'(lex_step(trial, b, eoi));
        if (!halt_allowed && trial.mode == LX_HALT) begin
            b = CH_SPACE;
            eoi = 1'b0;
            trial = plan_st;
            void'(lex_step(trial, b, eoi));
        end
        plan_st = trial;
        w = '0;
        w.b = b;
        w.eoi = eoi;
        src_words.push_back(w);
    endtask

    function automatic logic [7:0] rand_lead();
        int unsigned k;
        k = $urandom_range(52);
        if (k < 26) return 8'(8'h41 + k);
        if (k < 52) return 8'(8'h61 + k - 26);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] rand_name_byte();
        int unsigned k;
        k = $urandom_range(62);
        if (k < 53) return rand_lead();
        return 8'(8'h30 + k - 53);
    endfunction

    // Mostly well-formed token text with random content, plus stray bytes and end marks
    task automatic plan_random(input int unsigned n_words);
        int unsigned first_idx, pick, len, i;
        logic [7:0]  c;
        first_idx = src_words.size();
        while (src_words.size() - first_idx < n_words) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                len = $urandom_range(1, 12);
                if (plan_st.limit <= 40 && $urandom_range(5) == 0)
                    len = plan_st.limit + 1 + $urandom_range(2);
                plan_word(rand_lead(), 1'b0);
                for (i = 1; i < len; i++) plan_word(rand_name_byte(), 1'b0);
            end else if (pick < 50) begin
                plan_word(CH_QUOTE, 1'b0);
                len = $urandom_range(0, 10);
                for (i = 0; i < len; i++) begin
                    if ($urandom_range(4) == 0) begin
                        plan_word(CH_BSLASH, 1'b0);
                        c = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                     : ESC_TARGETS[$urandom_range(7)];
                        plan_word(c, 1'b0);
                    end else begin
                        c = 8'($urandom_range(255));
                        if (c == CH_QUOTE || c == CH_BSLASH) c = CH_LF;
                        plan_word(c, 1'b0);
                    end
                end
                // now and then the string is left open
                if ($urandom_range(9) != 0) plan_word(CH_QUOTE, 1'b0);
            end else if (pick < 65) begin
                case ($urandom_range(3))
                    0: plan_word(CH_SEMI, 1'b0);
                    1: plan_word(CH_COMMA, 1'b0);
                    2: plan_word(CH_OPEN, 1'b0);
                    default: plan_word(CH_CLOSE, 1'b0);
                endcase
            end else if (pick < 80) begin
                c = ($urandom_range(2) == 0) ? CH_SPACE : 8'($urandom_range(9, 13));
                plan_word(c, 1'b0);
            end else if (pick < 84) begin
                plan_word(8'($urandom_range(255)), 1'b1);
            end else begin
                plan_word(8'($urandom_range(255)), 1'b0);
            end
        end
    endtask

    // ---------------------------------------------------------------- bus drivers
    task automatic send_pending();
        src_word_t w;
        while (sent_idx < src_words.size()) begin
            w = src_words[sent_idx];
            @(negedge aclk);
            while (jitter_on && $urandom_range(99) < 27) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= w.b;
            s_tuser  <= w.eoi;
            do @(posedge aclk); while (!s_tready);
            sent_idx++;
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (token_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        data = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_limit_reg(input logic [8:0] want);
        logic [31:0] got;
        apb_read(ADDR_MAX_NAME_LEN, got);
        if (got != {23'd0, want})
            report_mismatch($sformatf("name limit reads %0d, want %0d", got, want));
    endtask

    // Upper write bits are junk; only the low nine land in the register
    task automatic set_name_limit(input logic [8:0] lim);
        apb_write(ADDR_MAX_NAME_LEN, {23'($urandom), lim});
        pred_st.limit = lim;
        plan_st.limit = lim;
        check_limit_reg(lim);
    endtask

    // ---------------------------------------------------------------- run sequence
    initial begin : run
        logic [8:0] mid_lim;
        int         i;
        pred_st = '{LX_IDLE, '0, '0, '0, MAX_NAME_LEN_RESET};
        plan_st = pred_st;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        check_limit_reg(MAX_NAME_LEN_RESET);

        // directed table at the reset limit, then random text
        foreach (DIRECTED[k]) begin
            void'(lex_step(plan_st, DIRECTED[k].b, DIRECTED[k].eoi));
            src_words.push_back(DIRECTED[k]);
        end
        plan_random(100);
        send_pending();
        drain();

        // shortest nonzero limit, with a long output stall while words keep coming
        set_name_limit(9'd1);
        plan_random(80);
        sink_hold = STALL_CYCLES;
        send_pending();
        drain();

        // longest limit: one long name past eight bits of length, no idling on either side
        set_name_limit(9'd511);
        jitter_on = 1'b0;
        plan_word(rand_lead(), 1'b0);
        for (i = 1; i < LONG_NAME_LEN; i++) plan_word(rand_name_byte(), 1'b0);
        plan_random(40);
        send_pending();
        drain();

        // a random mid limit with names running into it
        jitter_on = 1'b1;
        mid_lim = 9'($urandom_range(2, 40));
        set_name_limit(mid_lim);
        plan_random(50);
        send_pending();
        drain();

        // limit zero: the first name byte halts the block and all later words vanish
        set_name_limit(9'd0);
        halt_allowed = 1'b1;
        plan_word(8'h00, 1'b1);
        plan_word(CH_OPEN, 1'b0);
        plan_word(rand_lead(), 1'b0);
        plan_random(20);
        plan_word(8'h00, 1'b1);
        send_pending();
        drain();

        $display("Covered %0d source words and %0d tokens under name limits 255, 1, 511, %0d, 0.",
                 words_taken, tokens_seen, mid_lim);
        $display("Included a %0d-cycle output stall; lexer halted at the end: %0d.",
                 STALL_CYCLES, pred_st.mode == LX_HALT);
        if (mismatches == 0) begin
            $display("source_byte_tokenizer_top test passed");
        end else begin
            $display("source_byte_tokenizer_top test failed");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run
    initial begin
        #4000000;
        $display("source_byte_tokenizer_top test failed");
        $finish;
    end

endmodule

@@ source_byte_tokenizer_top.f @@
rtl/sbt_pkg.sv
rtl/sbt_step.sv
rtl/sbt_out_buf.sv
rtl/source_byte_tokenizer_top.sv
tb/testbench.sv
